// ===== src/ts_packet_timing_monitor_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef TS_PACKET_TIMING_MONITOR_MACROS_SVH
`define TS_PACKET_TIMING_MONITOR_MACROS_SVH

// Same-cycle implication.
`define PTM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ts_ptm_pkg.sv =====
package ts_ptm_pkg;

   localparam int PID_W   = 13;
   localparam int CC_W    = 4;
   localparam int PCR_W   = 42;
   localparam int CNT_W   = 32;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_PCR_PID = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PTS_PID = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DTS_PID = 2'd2;

   localparam logic [PID_W-1:0] PID_SEL_RESET = '1;

   localparam int NUM_SLOTS = 3;
   localparam int SLOT_W    = 2;
   localparam logic [SLOT_W-1:0] SLOT_PCR = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_PTS = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_DTS = 2'd2;

   localparam logic [CNT_W-1:0] PAYLOAD_BYTES = 32'd184;
   localparam logic [CNT_W-1:0] CNT_MAX       = '1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic [CC_W-1:0]  cont_count;
      logic             random_access;
      logic             pcr_present;
      logic [PCR_W-1:0] pcr_value;
      logic             pes_header_present;
      logic             pts_present;
      logic             dts_present;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] packet_number;
      logic             cc_error;
      logic             rap_flag;
      logic             pcr_taken;
      logic             pes_started;
      logic [CNT_W-1:0] pes_bytes;
      logic [PCR_W-1:0] pcr_low;
      logic [PCR_W-1:0] pcr_high;
      logic [CNT_W-1:0] pcr_low_index;
      logic [CNT_W-1:0] pcr_high_index;
      logic [CNT_W-1:0] lead_packets;
      logic [CNT_W-1:0] trail_packets;
   } rsp_item_type;

   typedef struct packed {
      logic              is_pcr;
      logic              is_ts;
      logic [SLOT_W-1:0] slot;
      logic              pes_start;
      logic [CC_W-1:0]   cont_count;
      logic              random_access;
      logic              pcr_present;
      logic [PCR_W-1:0]  pcr_value;
   } cls_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
   endfunction

endpackage

// ===== src/ts_ptm_req_if.sv =====
interface ts_ptm_req_if;
   logic                     valid;
   logic                     ready;
   ts_ptm_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ts_ptm_rsp_if.sv =====
interface ts_ptm_rsp_if;
   logic                     valid;
   logic                     ready;
   ts_ptm_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ts_ptm_queue.sv =====
module ts_ptm_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  ts_ptm_pkg::cls_item_type         push_item,
   input  logic                             pop,
   output ts_ptm_pkg::cls_item_type         head_item,
   output ts_ptm_pkg::queue_status_type     status
);

   ts_ptm_pkg::cls_item_type entry_ff [ts_ptm_pkg::QUEUE_DEPTH];

   logic [ts_ptm_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ts_ptm_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ts_ptm_pkg::QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (ts_ptm_pkg::QUEUE_AW+1)'(ts_ptm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== src/ts_ptm_front.sv =====
module ts_ptm_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [ts_ptm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ts_ptm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   ts_ptm_req_if.sink                              req_chan,
   input  ts_ptm_pkg::queue_status_type            queue_status,
   output logic                                    push,
   output ts_ptm_pkg::cls_item_type                push_item
);

   logic [ts_ptm_pkg::PID_W-1:0] pcr_sel_ff, pcr_sel_in;
   logic [ts_ptm_pkg::PID_W-1:0] pts_sel_ff, pts_sel_in;
   logic [ts_ptm_pkg::PID_W-1:0] dts_sel_ff, dts_sel_in;

   logic is_pcr;
   logic is_pts;
   logic is_dts;

   always_comb begin
      pcr_sel_in = pcr_sel_ff;
      pts_sel_in = pts_sel_ff;
      dts_sel_in = dts_sel_ff;
      if (csr_we) begin
         unique case (csr_index)
            ts_ptm_pkg::REG_PCR_PID: pcr_sel_in = csr_wdata[ts_ptm_pkg::PID_W-1:0];
            ts_ptm_pkg::REG_PTS_PID: pts_sel_in = csr_wdata[ts_ptm_pkg::PID_W-1:0];
            ts_ptm_pkg::REG_DTS_PID: dts_sel_in = csr_wdata[ts_ptm_pkg::PID_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcr_sel_ff <= ts_ptm_pkg::PID_SEL_RESET;
         pts_sel_ff <= ts_ptm_pkg::PID_SEL_RESET;
         dts_sel_ff <= ts_ptm_pkg::PID_SEL_RESET;
      end else begin
         pcr_sel_ff <= pcr_sel_in;
         pts_sel_ff <= pts_sel_in;
         dts_sel_ff <= dts_sel_in;
      end
   end

   assign is_pcr = (req_chan.payload.pid == pcr_sel_ff);
   assign is_pts = (req_chan.payload.pid == pts_sel_ff);
   assign is_dts = (req_chan.payload.pid == dts_sel_ff);

   // map each distinct PID onto the first slot that carries it
   always_comb begin
      push_item.is_pcr        = is_pcr;
      push_item.is_ts         = is_pts || is_dts;
      push_item.cont_count    = req_chan.payload.cont_count;
      push_item.random_access = req_chan.payload.random_access;
      push_item.pcr_present   = req_chan.payload.pcr_present;
      push_item.pcr_value     = req_chan.payload.pcr_value;
      push_item.pes_start     = req_chan.payload.pes_header_present &&
                                ((req_chan.payload.pts_present && is_pts) ||
                                 (req_chan.payload.dts_present && is_dts));
      if (is_pcr) begin
         push_item.slot = ts_ptm_pkg::SLOT_PCR;
      end else if (is_pts) begin
         push_item.slot = (pts_sel_ff == pcr_sel_ff) ? ts_ptm_pkg::SLOT_PCR
                                                     : ts_ptm_pkg::SLOT_PTS;
      end else if (dts_sel_ff == pcr_sel_ff) begin
         push_item.slot = ts_ptm_pkg::SLOT_PCR;
      end else if (dts_sel_ff == pts_sel_ff) begin
         push_item.slot = ts_ptm_pkg::SLOT_PTS;
      end else begin
         push_item.slot = ts_ptm_pkg::SLOT_DTS;
      end
   end

   assign req_chan.ready = !queue_status.full;
   assign push           = req_chan.valid && !queue_status.full;

endmodule

// ===== src/ts_ptm_back.sv =====
module ts_ptm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ts_ptm_pkg::cls_item_type      head_item,
   input  ts_ptm_pkg::queue_status_type  queue_status,
   output logic                          pop,
   ts_ptm_rsp_if.source                  rsp_chan
);

   logic [ts_ptm_pkg::CC_W-1:0]  cc_slot_ff [ts_ptm_pkg::NUM_SLOTS];
   logic [ts_ptm_pkg::CC_W-1:0]  cc_slot_in [ts_ptm_pkg::NUM_SLOTS];
   logic [ts_ptm_pkg::CNT_W-1:0] pkt_cnt_ff, pkt_cnt_in;
   logic [ts_ptm_pkg::PCR_W-1:0] min_pcr_ff, min_pcr_in;
   logic [ts_ptm_pkg::PCR_W-1:0] max_pcr_ff, max_pcr_in;
   logic [ts_ptm_pkg::CNT_W-1:0] min_idx_ff, min_idx_in;
   logic [ts_ptm_pkg::CNT_W-1:0] max_idx_ff, max_idx_in;
   logic [ts_ptm_pkg::CNT_W-1:0] lead_ff, lead_in;
   logic [ts_ptm_pkg::CNT_W-1:0] trail_ff, trail_in;
   logic                         seen_ff, seen_in;
   logic                         pes_open_ff, pes_open_in;
   logic [ts_ptm_pkg::CNT_W-1:0] pes_len_ff, pes_len_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   ts_ptm_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic [ts_ptm_pkg::CC_W-1:0] last_cc;
   logic                        monitored;
   logic                        cc_err;

   assign pop = !queue_status.empty && (!rsp_valid_ff || rsp_chan.ready);

   assign monitored = head_item.is_pcr || head_item.is_ts;

   always_comb begin
      last_cc = '0;
      for (int i = 0; i < ts_ptm_pkg::NUM_SLOTS; i++) begin
         if (head_item.slot == ts_ptm_pkg::SLOT_W'(i)) begin
            last_cc = cc_slot_ff[i];
         end
      end
   end

   assign cc_err = (head_item.cont_count != ts_ptm_pkg::CC_W'(last_cc + 1'b1)) &&
                   (head_item.cont_count != last_cc);

   always_comb begin
      for (int i = 0; i < ts_ptm_pkg::NUM_SLOTS; i++) begin
         cc_slot_in[i] = cc_slot_ff[i];
         if (monitored && head_item.slot == ts_ptm_pkg::SLOT_W'(i)) begin
            cc_slot_in[i] = head_item.cont_count;
         end
      end
      min_pcr_in  = min_pcr_ff;
      max_pcr_in  = max_pcr_ff;
      min_idx_in  = min_idx_ff;
      max_idx_in  = max_idx_ff;
      lead_in     = lead_ff;
      trail_in    = trail_ff;
      seen_in     = seen_ff;
      pes_open_in = pes_open_ff;
      pes_len_in  = pes_len_ff;
      pkt_cnt_in  = ts_ptm_pkg::sat_add(pkt_cnt_ff, ts_ptm_pkg::CNT_W'(1));

      if (head_item.is_pcr) begin
         if (head_item.pcr_present) begin
            seen_in  = 1'b1;
            trail_in = '0;
            if (head_item.pcr_value < min_pcr_ff) begin
               min_pcr_in = head_item.pcr_value;
               min_idx_in = pkt_cnt_ff;
            end
            if (head_item.pcr_value > max_pcr_ff) begin
               max_pcr_in = head_item.pcr_value;
               max_idx_in = pkt_cnt_ff;
            end
         end else begin
            if (!seen_ff) begin
               lead_in = ts_ptm_pkg::sat_add(lead_ff, ts_ptm_pkg::CNT_W'(1));
            end
            trail_in = ts_ptm_pkg::sat_add(trail_ff, ts_ptm_pkg::CNT_W'(1));
         end
      end

      if (head_item.is_ts) begin
         if (head_item.pes_start) begin
            pes_open_in = 1'b1;
            pes_len_in  = ts_ptm_pkg::PAYLOAD_BYTES;
         end else if (pes_open_ff) begin
            pes_len_in = ts_ptm_pkg::sat_add(pes_len_ff, ts_ptm_pkg::PAYLOAD_BYTES);
         end
      end
   end

   always_comb begin
      rsp_data_in.packet_number  = pkt_cnt_ff;
      rsp_data_in.cc_error       = monitored && cc_err;
      rsp_data_in.rap_flag       = monitored && head_item.random_access;
      rsp_data_in.pcr_taken      = head_item.is_pcr && head_item.pcr_present;
      rsp_data_in.pes_started    = head_item.is_ts && head_item.pes_start;
      rsp_data_in.pes_bytes      = pes_len_in;
      rsp_data_in.pcr_low        = min_pcr_in;
      rsp_data_in.pcr_high       = max_pcr_in;
      rsp_data_in.pcr_low_index  = min_idx_in;
      rsp_data_in.pcr_high_index = max_idx_in;
      rsp_data_in.lead_packets   = lead_in;
      rsp_data_in.trail_packets  = trail_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ts_ptm_pkg::NUM_SLOTS; i++) begin
            cc_slot_ff[i] <= '0;
         end
         pkt_cnt_ff   <= '0;
         min_pcr_ff   <= '1;
         max_pcr_ff   <= '0;
         min_idx_ff   <= '1;
         max_idx_ff   <= '0;
         lead_ff      <= '0;
         trail_ff     <= '0;
         seen_ff      <= 1'b0;
         pes_open_ff  <= 1'b0;
         pes_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            for (int i = 0; i < ts_ptm_pkg::NUM_SLOTS; i++) begin
               cc_slot_ff[i] <= cc_slot_in[i];
            end
            pkt_cnt_ff  <= pkt_cnt_in;
            min_pcr_ff  <= min_pcr_in;
            max_pcr_ff  <= max_pcr_in;
            min_idx_ff  <= min_idx_in;
            max_idx_ff  <= max_idx_in;
            lead_ff     <= lead_in;
            trail_ff    <= trail_in;
            seen_ff     <= seen_in;
            pes_open_ff <= pes_open_in;
            pes_len_ff  <= pes_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// ===== src/ts_packet_timing_monitor.sv =====
// Channel    Direction  Handshake          Payload
// req_chan   in         valid/ready        one parsed transport packet header
// rsp_chan   out        valid/ready        one monitor result per header
// csr_*      in         write enable only  PID selectors, index 0..2
//
// One header per cycle sustained while rsp ready stays high; a result is presented
// from the result register once its header has passed through the two-entry
// classify queue and been popped, and leaves at the first edge with rsp ready high.
// Throughput is set by the state update in the back end, which runs once per pop.
// Synchronous active-high reset clears selectors to 8191 and all monitor state.
// A stalled result holds the back end; the queue then fills and drops req ready.
module ts_packet_timing_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ts_ptm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ts_ptm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   ts_ptm_req_if.sink                         req_chan,
   ts_ptm_rsp_if.source                       rsp_chan
);

   logic                         push;
   logic                         pop;
   ts_ptm_pkg::cls_item_type     push_item;
   ts_ptm_pkg::cls_item_type     head_item;
   ts_ptm_pkg::queue_status_type queue_status;

   ts_ptm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   ts_ptm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   ts_ptm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

// ===== src/ts_ptm_checker.sv =====
`include "ts_packet_timing_monitor_macros.svh"

module ts_ptm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ts_ptm_pkg::rsp_item_type rsp_payload
);

   `PTM_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")
   `PTM_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload), "rsp payload changed while stalled")
   `PTM_ASSERT_NOW(a_pcr_order, clock, reset, rsp_valid && (rsp_payload.pcr_low_index != '1), rsp_payload.pcr_low <= rsp_payload.pcr_high, "pcr low above pcr high")
   `PTM_ASSERT_NOW(a_trail_clear, clock, reset, rsp_valid && rsp_payload.pcr_taken, rsp_payload.trail_packets == '0, "trail count not cleared on pcr")
   `PTM_ASSERT_NOW(a_pes_restart, clock, reset, rsp_valid && rsp_payload.pes_started, rsp_payload.pes_bytes == ts_ptm_pkg::PAYLOAD_BYTES, "pes length not restarted")

endmodule

bind ts_packet_timing_monitor ts_ptm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
